[rtl/core/cdq_pkg.sv]
// cdq_pkg: shared types and constants for the circular deque
// opcode and status codes, beat structs, and the cell command group
// no dependencies
`default_nettype none

package cdq_pkg;

    localparam int DATA_W        = 32;
    localparam int OCC_W         = 4;
    localparam int DEFAULT_DEPTH = 8;

    typedef enum logic [1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_POP_FRONT  = 2'd1,
        OP_PUSH_FRONT = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        op_t                        opcode;
        logic signed [DATA_W-1:0]   push_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   pop_value;
        status_t                    status;
        logic [OCC_W-1:0]           occupancy;
        logic                       is_empty;
        logic                       is_full;
    } rsp_t;

    // one successful operation per cycle at most; all zero means hold
    typedef struct packed {
        logic push_rear;
        logic pop_front;
        logic push_front;
        logic pop_rear;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/core/cdq_cell.sv]
// cdq_cell: one slot of the deque chain, front entries sit at low cells
// holds a word and its occupied flag, shifts with its neighbors
// depends on cdq_pkg
`default_nettype none

module cdq_cell
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire cdq_pkg::cmd_t                      cmd,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]  push_value,
    input  wire logic                               left_occ,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]  left_data,
    input  wire logic                               right_occ,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]  right_data,
    output      logic                               occ,
    output      logic signed [cdq_pkg::DATA_W-1:0]  data,
    output      logic                               last
);

    logic                               occ_reg;
    logic                               occ_next;
    logic signed [cdq_pkg::DATA_W-1:0]  data_reg;
    logic signed [cdq_pkg::DATA_W-1:0]  data_next;

    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        priority if (cmd.push_front)
        begin
            // whole chain moves one cell toward the rear
            occ_next  = left_occ;
            data_next = left_data;
        end
        else if (cmd.pop_front)
        begin
            occ_next  = right_occ;
            data_next = right_data;
        end
        else if (cmd.push_rear && !occ_reg && left_occ)
        begin
            // first free cell takes the word
            occ_next  = 1'b1;
            data_next = push_value;
        end
        else if (cmd.pop_rear && occ_reg && !right_occ)
        begin
            occ_next  = 1'b0;
        end
        else
        begin
            occ_next  = occ_reg;
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign occ  = occ_reg;
    assign data = data_reg;
    assign last = occ_reg && !right_occ;

endmodule

`default_nettype wire

[rtl/core/circular_deque.sv]
// circular_deque: top level of the double-ended queue
// depends on cdq_pkg and cdq_cell
//
// usage:
//   req beats carry an opcode (push rear, pop front, push front, pop rear)
//   and a push value; a beat is taken when req_valid is high and req_stall
//   is low. every req beat gives exactly one rsp beat, taken when rsp_valid
//   is high and rsp_stall is low.
//   rsp carries the popped word (zero unless a pop succeeded), a status
//   (ok, overflow on a push to a full deque, underflow on a pop from an
//   empty one), the occupancy after the operation and empty/full flags.
//   rsp_valid rises the cycle after a req beat; one beat per cycle is
//   sustained unless stalled. the entries live in a chain of DEPTH cells
//   with the front at cell 0, and each beat is one shift or one cell
//   update. pop at rear reads the one cell flagged as last through a one-hot
//   select. when the receiver stalls, the rsp register holds its beat and
//   req_stall rises, so no new req beat is taken until the rsp beat leaves.
//   reset empties the deque and clears rsp_valid; no clearing pass is needed.
`default_nettype none

module circular_deque
#(
    parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output      logic           req_stall,
    input  wire cdq_pkg::req_t  req,
    output      logic           rsp_valid,
    input  wire logic           rsp_stall,
    output      cdq_pkg::rsp_t  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                               accept;
    logic                               full;
    logic                               empty;
    cdq_pkg::cmd_t                      cmd;
    cdq_pkg::status_t                   status;
    logic signed [cdq_pkg::DATA_W-1:0]  popped;
    logic signed [cdq_pkg::DATA_W-1:0]  rear_word;

    logic                               cell_occ  [DEPTH];
    logic signed [cdq_pkg::DATA_W-1:0]  cell_data [DEPTH];
    logic                               cell_last [DEPTH];

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               rsp_valid_reg;
    logic                               rsp_valid_next;
    cdq_pkg::rsp_t                      rsp_reg;
    cdq_pkg::rsp_t                      rsp_next;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign full  = cell_occ[DEPTH-1];
    assign empty = !cell_occ[0];

    // one-hot select of the rear entry
    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_word = rear_word | (cell_data[i] & {cdq_pkg::DATA_W{cell_last[i]}});
        end
    end

    always_comb
    begin
        cmd        = '0;
        status     = cdq_pkg::ST_OK;
        popped     = '0;
        count_next = count_reg;
        if (accept)
        begin
            unique case (req.opcode)
                cdq_pkg::OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        status = cdq_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.push_rear = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                cdq_pkg::OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status = cdq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        cmd.pop_front = 1'b1;
                        popped        = cell_data[0];
                        count_next    = count_reg - 1'b1;
                    end
                end
                cdq_pkg::OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status = cdq_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.push_front = 1'b1;
                        count_next     = count_reg + 1'b1;
                    end
                end
                cdq_pkg::OP_POP_REAR:
                begin
                    if (empty)
                    begin
                        status = cdq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        cmd.pop_rear = 1'b1;
                        popped       = rear_word;
                        count_next   = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status = cdq_pkg::ST_OK;
                end
            endcase
        end
    end

    generate
        for (genvar g = 0; g < DEPTH; g++)
        begin : g_cell
            logic                               left_occ;
            logic signed [cdq_pkg::DATA_W-1:0]  left_data;
            logic                               right_occ;
            logic signed [cdq_pkg::DATA_W-1:0]  right_data;

            // cell 0 sees the incoming word as its left neighbor
            if (g == 0)
            begin : g_first
                assign left_occ  = 1'b1;
                assign left_data = req.push_value;
            end
            else
            begin : g_mid_l
                assign left_occ  = cell_occ[g-1];
                assign left_data = cell_data[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_end
                assign right_occ  = 1'b0;
                assign right_data = '0;
            end
            else
            begin : g_mid_r
                assign right_occ  = cell_occ[g+1];
                assign right_data = cell_data[g+1];
            end

            cdq_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .push_value (req.push_value),
                .left_occ   (left_occ),
                .left_data  (left_data),
                .right_occ  (right_occ),
                .right_data (right_data),
                .occ        (cell_occ[g]),
                .data       (cell_data[g]),
                .last       (cell_last[g])
            );
        end
    endgenerate

    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.pop_value = popped;
            rsp_next.status    = status;
            rsp_next.occupancy = cdq_pkg::OCC_W'(count_next);
            rsp_next.is_empty  = (count_next == '0);
            rsp_next.is_full   = (count_next == CNT_W'(DEPTH));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[tb/sv/circular_deque_tb.sv]
// circular_deque_tb: checks the deque against its own predictor, one rsp beat per req beat
// directed pops, front/rear pushes, overflow and underflow, then biased random traffic
// depends on cdq_pkg and circular_deque
`timescale 1ns / 1ps

module circular_deque_tb;

    import cdq_pkg::*;

    localparam int DEPTH       = DEFAULT_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int send_idle_pct = 0;
    int rcv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // predictor copy of the deque
    logic signed [DATA_W-1:0] slot_mem [DEPTH];
    int front_idx = 0;
    int rear_idx = DEPTH - 1;
    int held = 0;

    rsp_t rsp_due [$];

    circular_deque #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("circular_deque_tb NOT OK");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        rsp_stall = ($urandom_range(99) < rcv_stall_pct);
    end

    function automatic rsp_t apply_deque_op(req_t r);
        rsp_t o;
        o = '0;
        o.status = ST_OK;
        case (r.opcode)
            OP_PUSH_REAR:
                if (held == DEPTH)
                    o.status = ST_OVERFLOW;
                else
                begin
                    rear_idx = (rear_idx + 1) % DEPTH;
                    slot_mem[rear_idx] = r.push_value;
                    held++;
                end
            OP_POP_FRONT:
                if (held == 0)
                    o.status = ST_UNDERFLOW;
                else
                begin
                    o.pop_value = slot_mem[front_idx];
                    front_idx = (front_idx + 1) % DEPTH;
                    held--;
                end
            OP_PUSH_FRONT:
                if (held == DEPTH)
                    o.status = ST_OVERFLOW;
                else
                begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    slot_mem[front_idx] = r.push_value;
                    held++;
                end
            OP_POP_REAR:
                if (held == 0)
                    o.status = ST_UNDERFLOW;
                else
                begin
                    o.pop_value = slot_mem[rear_idx];
                    rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
                    held--;
                end
        endcase
        o.occupancy = OCC_W'(held);
        o.is_empty = (held == 0);
        o.is_full = (held == DEPTH);
        return o;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at cycle %0d",
                 field, got, want, cycle_count);
        mismatch_count++;
    endtask

    // predict on each req beat, then check each rsp beat against the oldest prediction
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                rsp_due.push_back(apply_deque_op(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_due.size() == 0)
                    report_mismatch("rsp beat with none due", rsp.pop_value, 32'd0);
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp.pop_value !== want.pop_value)
                        report_mismatch("pop_value", rsp.pop_value, want.pop_value);
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.occupancy !== want.occupancy)
                        report_mismatch("occupancy", rsp.occupancy, want.occupancy);
                    if (rsp.is_empty !== want.is_empty)
                        report_mismatch("is_empty", rsp.is_empty, want.is_empty);
                    if (rsp.is_full !== want.is_full)
                        report_mismatch("is_full", rsp.is_full, want.is_full);
                end
            end
        end
    end

    // returns at the rising edge where the beat is taken; valid stays high until the next call
    task automatic send_op(input op_t op, input logic signed [DATA_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req.opcode = op;
        req.push_value = value;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh00000000;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_pops();
        send_op(OP_POP_FRONT, 32'sh0);
        send_op(OP_POP_REAR, -32'sd1);
    endtask

    // rear pop right after front pushes must see the first front entry
    task automatic test_rear_pop_after_front_pushes();
        send_op(OP_PUSH_FRONT, 32'sh0badcafe);
        send_op(OP_PUSH_FRONT, 32'sh13579bdf);
        send_op(OP_POP_REAR, 32'sh0);
        send_op(OP_POP_REAR, 32'sh0);
    endtask

    task automatic test_fill_overflow_drain();
        send_op(OP_PUSH_REAR, 32'sh7fffffff);
        send_op(OP_PUSH_REAR, 32'sh80000000);
        send_op(OP_PUSH_REAR, 32'sh00000000);
        send_op(OP_PUSH_REAR, -32'sd1);
        send_op(OP_PUSH_REAR, 32'sh55555555);
        send_op(OP_PUSH_REAR, 32'shaaaaaaaa);
        send_op(OP_PUSH_REAR, 32'sh00000001);
        send_op(OP_PUSH_REAR, 32'sh12345678);
        send_op(OP_PUSH_REAR, 32'sh11111111);
        send_op(OP_PUSH_FRONT, 32'sh22222222);
        for (int i = 0; i < DEPTH; i++)
            send_op((i % 2 == 0) ? OP_POP_FRONT : OP_POP_REAR, 32'sh0);
    endtask

    // push bias drifts every few beats so occupancy swings between empty and full
    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        int push_bias;
        op_t op;
        push_bias = 50;
        send_idle_pct = idle_pct;
        rcv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
                push_bias = $urandom_range(90, 10);
            if ($urandom_range(99) < push_bias)
                op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            else
                op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
            send_op(op, pick_value());
        end
    endtask

    initial
    begin
        send_idle_pct = 30;
        rcv_stall_pct = 80;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_pops();
        test_rear_pop_after_front_pushes();
        test_fill_overflow_drain();
        test_random_traffic(342, 30, 80);
        test_random_traffic(342, 80, 30);
        test_random_traffic(342, 0, 0);

        @(negedge clk);
        req_valid = 1'b0;
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("circular_deque_tb OK");
        else
            $display("circular_deque_tb NOT OK");
        $finish;
    end

endmodule
